FILE: hw/rtl/rcw_pkg.sv
// Shared types, constants and the cosine table for the raycast wall column setup unit.
// No dependencies; every other file of the block refers to it by scoped names.

package rcw_pkg;

  // Screen and table geometry.
  localparam int SCREEN_H  = 512;
  localparam int COS_DEPTH = 256;
  localparam int COS_AW    = 8;
  localparam int FRAC_W    = 14;
  localparam int VAL_W     = 24;
  localparam int SIZE_W    = 11;
  localparam int TEX_MAX   = 1024;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;

  // Pipelined restoring divider geometry.
  localparam int DIV_NW  = 39;
  localparam int DIV_DW  = 38;
  localparam int DIV_BPS = 3;
  localparam int DIV_NS  = DIV_NW / DIV_BPS;

  // Line height width and the constant dividend of the line height divide.
  localparam int LH_W = 38;
  localparam logic [DIV_NW-1:0] LH_NUM = DIV_NW'(SCREEN_H) << 28;

  // Pipeline stage positions.
  localparam int ST_IN  = 0;
  localparam int ST_COS = 1;
  localparam int ST_MUL = 2;
  localparam int ST_D1  = 3;
  localparam int ST_COL = 4;
  localparam int ST_LH  = ST_D1 + DIV_NS;
  localparam int ST_D2  = ST_LH + 1;
  localparam int ST_PP  = ST_D2 + DIV_NS;
  localparam int ST_OUT = ST_PP + 1;
  localparam int NSTG   = ST_OUT + 1;

  // Wall faces.
  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_WEST  = 2'd2,
    FACE_EAST  = 2'd3
  } face_t;

  // Configuration register indexes.
  typedef enum logic [3:0] {
    REG_NORTH_W = 4'd0,
    REG_SOUTH_W = 4'd1,
    REG_WEST_W  = 4'd2,
    REG_EAST_W  = 4'd3,
    REG_NORTH_H = 4'd4,
    REG_SOUTH_H = 4'd5,
    REG_WEST_H  = 4'd6,
    REG_EAST_H  = 4'd7
  } reg_idx_t;

  // Per-item state that travels down the pipeline next to the dividers.
  typedef struct packed {
    logic [VAL_W-1:0]         d;
    face_t                    face;
    logic                     yside;
    logic                     flip;
    logic signed [15:0]       rd;
    logic [FRAC_W-1:0]        pos;
    logic [SIZE_W-1:0]        w;
    logic [SIZE_W-1:0]        h;
    logic [COS_AW-1:0]        idx;
    logic [15:0]              c;
    logic [27:0]              tprod;
    logic [25:0]              p;
    logic [FRAC_W-1:0]        frac;
    logic [24:0]              t;
    logic [COL_W-1:0]         col;
    logic [LH_W-1:0]          lhx;
    logic                     rs_en;
    logic                     sat;
    logic [ROW_W-1:0]         srow;
    logic [ROW_W-1:0]         erow;
    logic [VAL_W-1:0]         step;
    logic [34:0]              pp_lo;
    logic [34:0]              pp_hi;
    logic [VAL_W-1:0]         rstart;
  } side_t;

  typedef logic [15:0] cos_tab_t [COS_DEPTH];

  // Texture sizes are kept within 1..TEX_MAX.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > SIZE_W'(TEX_MAX)) r = SIZE_W'(TEX_MAX);
    return r;
  endfunction

  // Cosine in Q1.14 by a truncated Taylor series in Q30, evaluated at elaboration.
  function automatic cos_tab_t build_cos();
    cos_tab_t tab;
    longint unsigned x, x2, t;
    for (int k = 0; k < COS_DEPTH; k++) begin
      x  = (longint'(k) << 30) / COS_DEPTH;
      x2 = (x * x) >> 30;
      t  = (64'd1 << 30) - x2 / 56;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 30;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 12;
      t  = (64'd1 << 30) - ((x2 * t) >> 30) / 2;
      tab[k] = 16'((t + (64'd1 << 15)) >> 16);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_cos();

endpackage

FILE: hw/rtl/rcw_div.sv
// Pipelined restoring divider, three quotient bits per stage, one divide per cycle while all stage enables are set.
// Depends on rcw_pkg for its widths and stage count.

module rcw_div (
  input  logic                              clk,
  input  logic [rcw_pkg::DIV_NS-1:0]        en,
  input  logic [rcw_pkg::DIV_NW-1:0]        num,
  input  logic [rcw_pkg::DIV_DW-1:0]        den,
  output logic [rcw_pkg::DIV_NW-1:0]        quo
);

  localparam int NW = rcw_pkg::DIV_NW;
  localparam int DW = rcw_pkg::DIV_DW;
  localparam int NS = rcw_pkg::DIV_NS;

  logic [DW-1:0] rem_r [NS];
  logic [NW-1:0] num_r [NS];
  logic [DW-1:0] den_r [NS];
  logic [NW-1:0] quo_r [NS];

  logic [DW-1:0] rem_nxt [NS];
  logic [NW-1:0] num_nxt [NS];
  logic [NW-1:0] quo_nxt [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stg
    logic [DW-1:0] rem_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] quo_in;

    // Stage inputs come from the ports for the first stage.
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign num_in = num_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    // DIV_BPS (3) shift-and-subtract steps per stage.
    always_comb begin
      logic [DW:0]   sh;
      logic [DW-1:0] rm;
      logic [NW-1:0] nm;
      logic [NW-1:0] qt;
      logic          qb;
      rm = rem_in;
      nm = num_in;
      qt = quo_in;
      for (int b = 0; b < rcw_pkg::DIV_BPS; b++) begin
        sh = {rm, nm[NW-1]};
        nm = {nm[NW-2:0], 1'b0};
        qb = (sh >= {1'b0, den_in});
        if (qb) sh = sh - {1'b0, den_in};
        rm = sh[DW-1:0];
        qt = {qt[NW-2:0], qb};
      end
      rem_nxt[s] = rm;
      num_nxt[s] = nm;
      quo_nxt[s] = qt;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s] <= rem_nxt[s];
        num_r[s] <= num_nxt[s];
        den_r[s] <= den_in;
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign quo = quo_r[NS-1];

endmodule

FILE: hw/rtl/raycast_wall_column_setup_unit.sv
// Raycast wall column setup: depth, face, span rows and texture mapping per screen column.
// Depends on rcw_pkg and on rcw_div for the line height and texture step divides.
//
//   Channel | Direction | Handshake          | Content
//   in_     | slave     | tvalid/tready      | one column's grid walk result
//   out_    | master    | tvalid/tready      | one column's wall setup
//   cfg_    | slave     | valid/ready        | texture width/height registers
//
// One column enters per cycle unless an output stall backs up; the unit has two 13-stage
// dividers (3 quotient bits per stage) plus the multiply and select stages around them.
// Reset clears only the stage valid bits and sets the texture size registers to 64.
// A stall at the output collapses bubbles stage by stage; nothing is lost or repeated.

module raycast_wall_column_setup_unit (
  input  logic         clk,
  input  logic         rst_n,
  // side_dist_x, side_dist_y, delta_x, delta_y, ray_dir_x, ray_dir_y,
  // angle_offset, player_x, player_y, zero pad
  input  logic [199:0] in_tdata,
  // hit_y_side, step_x_negative, step_y_negative
  input  logic [2:0]   in_tuser,
  input  logic         in_tvalid,
  output logic         in_tready,
  // depth, span_start_row, span_end_row, texture_column, texture_row_start,
  // texture_row_step, zero pad
  output logic [111:0] out_tdata,
  // wall_face
  output logic [1:0]   out_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [10:0]  cfg_data
);

  localparam int NSTG   = rcw_pkg::NSTG;
  localparam int VAL_W  = rcw_pkg::VAL_W;
  localparam int SIZE_W = rcw_pkg::SIZE_W;
  localparam int LH_W   = rcw_pkg::LH_W;

  // Input field unpacking.
  logic [23:0]        side_dist_x, side_dist_y, delta_x, delta_y, player_x, player_y;
  logic signed [15:0] ray_dir_x, ray_dir_y;
  logic signed [17:0] angle_offset;
  logic               hit_y_side, step_x_negative, step_y_negative;

  assign side_dist_x     = in_tdata[23:0];
  assign side_dist_y     = in_tdata[47:24];
  assign delta_x         = in_tdata[71:48];
  assign delta_y         = in_tdata[95:72];
  assign ray_dir_x       = in_tdata[111:96];
  assign ray_dir_y       = in_tdata[127:112];
  assign angle_offset    = in_tdata[145:128];
  assign player_x        = in_tdata[169:146];
  assign player_y        = in_tdata[193:170];
  assign hit_y_side      = in_tuser[0];
  assign step_x_negative = in_tuser[1];
  assign step_y_negative = in_tuser[2];

  // Texture size registers, indexed by face.
  logic [SIZE_W-1:0] tex_w_r [4];
  logic [SIZE_W-1:0] tex_h_r [4];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        tex_w_r[i] <= SIZE_W'(64);
        tex_h_r[i] <= SIZE_W'(64);
      end
    end else if (cfg_valid) begin
      case (rcw_pkg::reg_idx_t'(cfg_index))
        rcw_pkg::REG_NORTH_W: tex_w_r[rcw_pkg::FACE_NORTH] <= cfg_data;
        rcw_pkg::REG_SOUTH_W: tex_w_r[rcw_pkg::FACE_SOUTH] <= cfg_data;
        rcw_pkg::REG_WEST_W:  tex_w_r[rcw_pkg::FACE_WEST]  <= cfg_data;
        rcw_pkg::REG_EAST_W:  tex_w_r[rcw_pkg::FACE_EAST]  <= cfg_data;
        rcw_pkg::REG_NORTH_H: tex_h_r[rcw_pkg::FACE_NORTH] <= cfg_data;
        rcw_pkg::REG_SOUTH_H: tex_h_r[rcw_pkg::FACE_SOUTH] <= cfg_data;
        rcw_pkg::REG_WEST_H:  tex_h_r[rcw_pkg::FACE_WEST]  <= cfg_data;
        rcw_pkg::REG_EAST_H:  tex_h_r[rcw_pkg::FACE_EAST]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage valid bits and bubble-collapsing ready chain.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] rdy;

  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt = {v_r[NSTG-2:0], in_tvalid};
  end

  assign in_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) v_r[k] <= v_nxt[k];
      end
    end
  end

  // Side data registers per stage.
  rcw_pkg::side_t sd_r   [NSTG];
  rcw_pkg::side_t sd_nxt [NSTG];

  // Divider connections.
  logic [rcw_pkg::DIV_NW-1:0] d1_quo, d2_quo;
  logic [rcw_pkg::DIV_DW-1:0] d1_den, d2_den;
  logic [rcw_pkg::DIV_NW-1:0] d2_num;

  // Stage logic.
  always_comb begin
    logic [17:0]               mag;
    logic [17-(16-rcw_pkg::COS_AW):0] idx_w;
    logic signed [40:0]        tp;
    logic [39:0]               pc;
    logic signed [26:0]        tf;
    logic [SIZE_W-1:0]         cand;
    logic [LH_W-1:0]           lh;
    logic [LH_W-1:0]           endq;
    logic [LH_W-1:0]           hl;
    logic [53:0]               acc;
    logic [38:0]               rs;
    rcw_pkg::side_t            s0;

    for (int k = 1; k < NSTG; k++) sd_nxt[k] = sd_r[k-1];

    // Input stage: depth, face, texture sizes and table index.
    s0 = '0;
    s0.yside = hit_y_side;
    if (hit_y_side) begin
      s0.d    = (side_dist_y >= delta_y) ? side_dist_y - delta_y : '0;
      s0.face = step_y_negative ? rcw_pkg::FACE_NORTH : rcw_pkg::FACE_SOUTH;
      s0.flip = !step_y_negative;
      s0.rd   = ray_dir_x;
      s0.pos  = player_x[rcw_pkg::FRAC_W-1:0];
    end else begin
      s0.d    = (side_dist_x >= delta_x) ? side_dist_x - delta_x : '0;
      s0.face = step_x_negative ? rcw_pkg::FACE_WEST : rcw_pkg::FACE_EAST;
      s0.flip = step_x_negative;
      s0.rd   = ray_dir_y;
      s0.pos  = player_y[rcw_pkg::FRAC_W-1:0];
    end
    s0.w = rcw_pkg::clamp_size(tex_w_r[s0.face]);
    s0.h = rcw_pkg::clamp_size(tex_h_r[s0.face]);
    mag   = angle_offset[17] ? 18'(-angle_offset) : 18'(angle_offset);
    idx_w = mag[17:16-rcw_pkg::COS_AW];
    // Any bit above the table address means the offset is past the last entry.
    if (idx_w[rcw_pkg::COS_AW+1:rcw_pkg::COS_AW] != 2'b00) s0.idx = '1;
    else s0.idx = idx_w[rcw_pkg::COS_AW-1:0];
    sd_nxt[rcw_pkg::ST_IN] = s0;

    // Cosine lookup and ray product for the texture position.
    sd_nxt[rcw_pkg::ST_COS].c = rcw_pkg::COS_TAB[sd_r[rcw_pkg::ST_IN].idx];
    tp = $signed({1'b0, sd_r[rcw_pkg::ST_IN].d}) * sd_r[rcw_pkg::ST_IN].rd;
    sd_nxt[rcw_pkg::ST_COS].tprod = tp[27:0];

    // Corrected distance and fractional wall hit position.
    pc = 40'(sd_r[rcw_pkg::ST_COS].d) * 40'(sd_r[rcw_pkg::ST_COS].c);
    sd_nxt[rcw_pkg::ST_MUL].p = pc[39:14];
    if (sd_r[rcw_pkg::ST_COS].yside)
      sd_nxt[rcw_pkg::ST_MUL].frac = sd_r[rcw_pkg::ST_COS].pos + sd_r[rcw_pkg::ST_COS].tprod[27:14];
    else
      sd_nxt[rcw_pkg::ST_MUL].frac = sd_r[rcw_pkg::ST_COS].pos - sd_r[rcw_pkg::ST_COS].tprod[27:14];

    // Texel position along the wall.
    sd_nxt[rcw_pkg::ST_D1].t = 25'(sd_r[rcw_pkg::ST_MUL].frac) * 25'(sd_r[rcw_pkg::ST_MUL].w);

    // Texture column with flip and clamp.
    tf = $signed({2'b00, sd_r[rcw_pkg::ST_D1].w, 14'd0})
       - $signed({2'b00, sd_r[rcw_pkg::ST_D1].t}) - 27'sd16384;
    if (sd_r[rcw_pkg::ST_D1].flip) begin
      if (tf < 0) cand = '0;
      else cand = tf[24:14];
    end else begin
      cand = {1'b0, sd_r[rcw_pkg::ST_D1].t[23:14]};
    end
    if (cand > sd_r[rcw_pkg::ST_D1].w - SIZE_W'(1))
      cand = sd_r[rcw_pkg::ST_D1].w - SIZE_W'(1);
    sd_nxt[rcw_pkg::ST_COL].col = cand[rcw_pkg::COL_W-1:0];

    // Span rows, step saturation and texture start setup from the line height.
    lh   = d1_quo[LH_W-1:0];
    hl   = lh >> 1;
    endq = LH_W'(rcw_pkg::SCREEN_H << 13) + hl;
    if (endq > LH_W'((rcw_pkg::SCREEN_H - 1) << 14)) begin
      sd_nxt[rcw_pkg::ST_LH].erow = rcw_pkg::ROW_W'(rcw_pkg::SCREEN_H - 1);
      sd_nxt[rcw_pkg::ST_LH].srow = '0;
    end else begin
      sd_nxt[rcw_pkg::ST_LH].erow = endq[25:14];
      sd_nxt[rcw_pkg::ST_LH].srow = 12'((LH_W'(rcw_pkg::SCREEN_H << 13) - hl) >> 14);
    end
    sd_nxt[rcw_pkg::ST_LH].sat   = ({sd_r[rcw_pkg::ST_LH-1].h, 4'd0} >= lh);
    sd_nxt[rcw_pkg::ST_LH].rs_en = (lh > LH_W'(rcw_pkg::SCREEN_H << 14));
    sd_nxt[rcw_pkg::ST_LH].lhx   = lh - LH_W'(rcw_pkg::SCREEN_H << 14);

    // Row step and the two partial products of the texture start.
    sd_nxt[rcw_pkg::ST_PP].step  = sd_r[rcw_pkg::ST_PP-1].sat ? '1 : d2_quo[VAL_W-1:0];
    sd_nxt[rcw_pkg::ST_PP].pp_lo = 35'(d2_quo[15:0]) * 35'(sd_r[rcw_pkg::ST_PP-1].lhx[18:0]);
    sd_nxt[rcw_pkg::ST_PP].pp_hi = 35'(d2_quo[15:0]) * 35'(sd_r[rcw_pkg::ST_PP-1].lhx[37:19]);

    // Texture start row sum with saturation.
    acc = {sd_r[rcw_pkg::ST_PP].pp_hi, 19'd0} + 54'(sd_r[rcw_pkg::ST_PP].pp_lo);
    rs  = acc[53:15];
    if (!sd_r[rcw_pkg::ST_PP].rs_en) sd_nxt[rcw_pkg::ST_OUT].rstart = '0;
    else if (|rs[38:24]) sd_nxt[rcw_pkg::ST_OUT].rstart = '1;
    else sd_nxt[rcw_pkg::ST_OUT].rstart = rs[23:0];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) sd_r[k] <= sd_nxt[k];
    end
  end

  // Line height divide: SCREEN_H in Q28 over the corrected distance.
  assign d1_den = (sd_r[rcw_pkg::ST_MUL].p == '0) ? rcw_pkg::DIV_DW'(1)
                                                  : rcw_pkg::DIV_DW'(sd_r[rcw_pkg::ST_MUL].p);

  rcw_div u_div_lh (
    .clk (clk),
    .en  (rdy[rcw_pkg::ST_D1 +: rcw_pkg::DIV_NS]),
    .num (rcw_pkg::LH_NUM),
    .den (d1_den),
    .quo (d1_quo)
  );

  // Texture step divide: texture height in Q28 over the line height.
  assign d2_num = {sd_r[rcw_pkg::ST_LH].h, 28'd0};
  assign d2_den = sd_r[rcw_pkg::ST_LH].lhx + LH_W'(rcw_pkg::SCREEN_H << 14);

  rcw_div u_div_step (
    .clk (clk),
    .en  (rdy[rcw_pkg::ST_D2 +: rcw_pkg::DIV_NS]),
    .num (d2_num),
    .den (d2_den),
    .quo (d2_quo)
  );

  // Result packing.
  assign out_tvalid = v_r[NSTG-1];
  assign out_tuser  = sd_r[rcw_pkg::ST_OUT].face;
  assign out_tdata  = {6'd0,
                       sd_r[rcw_pkg::ST_OUT].step,
                       sd_r[rcw_pkg::ST_OUT].rstart,
                       sd_r[rcw_pkg::ST_OUT].col,
                       sd_r[rcw_pkg::ST_OUT].erow,
                       sd_r[rcw_pkg::ST_OUT].srow,
                       sd_r[rcw_pkg::ST_OUT].d};

endmodule

FILE: hw/rtl/rcw_checker.sv
// Port-level checks for the raycast wall column setup unit, attached by bind.
// Depends on rcw_pkg for the screen height.

module rcw_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic [111:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tvalid,
  input logic         out_tready
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // With no result waiting the input side is always open.
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input blocked while output free");

  // Wall span stays on screen and ordered.
  a_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:36] <= 12'(rcw_pkg::SCREEN_H - 1))
                && (out_tdata[35:24] <= out_tdata[47:36]))
    else $error("wall span out of range");

endmodule

bind raycast_wall_column_setup_unit rcw_checker u_rcw_checker (.*);
